/* sv/shamh_pkg.sv */
// Shared types, constants and a helper function for the SHA-256 message hasher.
package shamh_pkg;

   typedef logic [31:0] word_type;

   // Eight 32-bit words; index 0 is word A (most significant digest word).
   typedef logic [7:0][31:0] hash_type;

   // Sequencer controls for the round unit
   typedef struct packed {
      logic load;    // copy chaining words into the working registers
      logic round;   // run one compression round
   } core_ctl_type;

   // SHA-256 initial hash values, index 7 listed first
   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam int unsigned ROUNDS = 64;

   // Round constants
   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Rotate right by a constant amount
   function automatic word_type rotr(word_type v, int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

endpackage

/* sv/shamh_core.sv */
// SHA-256 round unit: working registers A..H and one compression round per cycle while ctl.round is set.
module shamh_core (
   input  logic                   clock,
   input  shamh_pkg::core_ctl_type ctl,
   input  shamh_pkg::hash_type    chain,
   input  shamh_pkg::word_type    sched_word,
   input  logic [5:0]             round_idx,
   output shamh_pkg::hash_type    work
);
   import shamh_pkg::*;

   hash_type work_ff;
   hash_type work_in;
   hash_type round_out;

   word_type t1;
   word_type t2;
   word_type big_s0;
   word_type big_s1;
   word_type ch;
   word_type maj;

   // One round of the compression function
   always_comb begin
      big_s1 = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
      ch     = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      big_s0 = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
      maj    = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
               (work_ff[1] & work_ff[2]);
      t1     = work_ff[7] + big_s1 + ch + ROUND_K[round_idx] + sched_word;
      t2     = big_s0 + maj;
      round_out[0] = t1 + t2;
      round_out[1] = work_ff[0];
      round_out[2] = work_ff[1];
      round_out[3] = work_ff[2];
      round_out[4] = work_ff[3] + t1;
      round_out[5] = work_ff[4];
      round_out[6] = work_ff[5];
      round_out[7] = work_ff[6];
   end

   // Load from chaining words or advance by a round
   always_comb begin
      work_in = work_ff;
      if (ctl.load) begin
         work_in = chain;
      end else if (ctl.round) begin
         work_in = round_out;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule

/* sv/sha256_message_hasher_unit.sv */
// Top level of the SHA-256 message hasher: byte intake, padding, sequencer and digest output.
//
// Takes a message one byte per beat and returns its SHA-256 digest as eight 32-bit beats,
// word 0 (most significant) first. The beat that completes a 64-byte block holds off
// further input while the block runs through the single shared round unit and then the
// chaining add. A beat with end_of_message passes its byte, then a padding state and one
// padded block, or two when the marker and length do not fit in the current block (a
// byte that fills the block adds one more block first). The digest sits in its own output
// register, so the next message streams in while the eight result beats drain; the next
// digest waits in the chaining add until the previous one has been fully taken. too_long
// is set on all eight beats when the message held more than 2^61-1 bytes.
module sha256_message_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_too_long
);
   import shamh_pkg::*;

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_PAD2  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_ADD   = 3'd4;

   // Where to go after a block's chaining add
   localparam logic [1:0] AFT_IDLE = 2'd0;
   localparam logic [1:0] AFT_PAD  = 2'd1;
   localparam logic [1:0] AFT_PAD2 = 2'd2;
   localparam logic [1:0] AFT_DONE = 2'd3;

   localparam logic [5:0] LAST_BYTE = 6'd63;
   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [5:0] LAST_RND  = 6'(ROUNDS - 1);

   logic [2:0]  state_ff, state_in;
   logic [1:0]  after_ff, after_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic [5:0]  round_ff, round_in;
   hash_type    chain_ff, chain_in;
   word_type    sched_ff [16];
   word_type    sched_in [16];
   hash_type    out_ff, out_in;
   logic [3:0]  out_cnt_ff, out_cnt_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        tl_ff, tl_in;

   core_ctl_type ctl;
   hash_type     work;
   hash_type     digest;
   word_type     sched_new;
   word_type     small_s0;
   word_type     small_s1;
   logic [63:0]  bit_len;

   assign bit_len = {count_ff[60:0], 3'b000};

   // Next message-schedule word
   always_comb begin
      small_s0  = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      small_s1  = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      sched_new = sched_ff[0] + small_s0 + sched_ff[9] + small_s1;
   end

   // Chaining add
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest[i] = chain_ff[i] + work[i];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer and datapath next state
   always_comb begin
      state_in   = state_ff;
      after_in   = after_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      round_in   = round_ff;
      chain_in   = chain_ff;
      sched_in   = sched_ff;
      out_in     = out_ff;
      out_cnt_in = out_cnt_ff;
      out_idx_in = out_idx_ff;
      tl_in      = tl_ff;
      ctl        = '0;

      // drain one digest beat
      if (rsp_valid && rsp_ready) begin
         for (int i = 0; i < 7; i++) begin
            out_in[i] = out_ff[i + 1];
         end
         out_cnt_in = out_cnt_ff - 4'd1;
         out_idx_in = out_idx_ff + 3'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  case (fill_ff[1:0])
                     2'd0:    sched_in[fill_ff[5:2]][31:24] = req_data_byte;
                     2'd1:    sched_in[fill_ff[5:2]][23:16] = req_data_byte;
                     2'd2:    sched_in[fill_ff[5:2]][15:8]  = req_data_byte;
                     default: sched_in[fill_ff[5:2]][7:0]   = req_data_byte;
                  endcase
                  count_in = count_ff + 64'd1;
                  if (count_in[63:61] != 3'd0) begin
                     ovf_in = 1'b1;
                  end
                  if (fill_ff == LAST_BYTE) begin
                     fill_in  = '0;
                     ctl.load = 1'b1;
                     round_in = '0;
                     state_in = ST_ROUND;
                     after_in = req_end_of_message ? AFT_PAD : AFT_IDLE;
                  end else begin
                     fill_in = fill_ff + 6'd1;
                     if (req_end_of_message) begin
                        state_in = ST_PAD;
                     end
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end

         // marker byte, zero tail, and the length when it fits
         ST_PAD: begin
            for (int wi = 0; wi < 16; wi++) begin
               for (int li = 0; li < 4; li++) begin
                  if (6'(4 * wi + li) == fill_ff) begin
                     sched_in[wi][31 - 8 * li -: 8] = 8'h80;
                  end else if (6'(4 * wi + li) > fill_ff) begin
                     sched_in[wi][31 - 8 * li -: 8] = 8'h00;
                  end
               end
            end
            if (fill_ff >= LEN_START) begin
               after_in = AFT_PAD2;
            end else begin
               sched_in[14] = bit_len[63:32];
               sched_in[15] = bit_len[31:0];
               after_in     = AFT_DONE;
            end
            ctl.load = 1'b1;
            round_in = '0;
            state_in = ST_ROUND;
         end

         // extra block: zeros and the length
         ST_PAD2: begin
            for (int wi = 0; wi < 14; wi++) begin
               sched_in[wi] = '0;
            end
            sched_in[14] = bit_len[63:32];
            sched_in[15] = bit_len[31:0];
            after_in     = AFT_DONE;
            ctl.load     = 1'b1;
            round_in     = '0;
            state_in     = ST_ROUND;
         end

         // one round per cycle, schedule rolls with it
         ST_ROUND: begin
            ctl.round = 1'b1;
            for (int i = 0; i < 15; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[15] = sched_new;
            round_in     = round_ff + 6'd1;
            if (round_ff == LAST_RND) begin
               state_in = ST_ADD;
            end
         end

         ST_ADD: begin
            case (after_ff)
               AFT_IDLE: begin
                  chain_in = digest;
                  state_in = ST_IDLE;
               end
               AFT_PAD: begin
                  chain_in = digest;
                  state_in = ST_PAD;
               end
               AFT_PAD2: begin
                  chain_in = digest;
                  state_in = ST_PAD2;
               end
               default: begin
                  // hold until the previous digest is fully taken
                  if (out_cnt_ff == 4'd0) begin
                     out_in     = digest;
                     out_cnt_in = 4'd8;
                     out_idx_in = '0;
                     tl_in      = ovf_ff;
                     chain_in   = INIT_HASH;
                     fill_in    = '0;
                     count_in   = '0;
                     ovf_in     = 1'b0;
                     state_in   = ST_IDLE;
                  end
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         after_ff   <= AFT_IDLE;
         fill_ff    <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         round_ff   <= '0;
         chain_ff   <= INIT_HASH;
         out_cnt_ff <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         after_ff   <= after_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         round_ff   <= round_in;
         chain_ff   <= chain_in;
         out_cnt_ff <= out_cnt_in;
         out_idx_ff <= out_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      out_ff   <= out_in;
      tl_ff    <= tl_in;
   end

   shamh_core u_core (
      .clock      (clock),
      .ctl        (ctl),
      .chain      (chain_ff),
      .sched_word (sched_ff[0]),
      .round_idx  (round_ff),
      .work       (work)
   );

   assign rsp_valid       = (out_cnt_ff != 4'd0);
   assign rsp_digest_word = out_ff[0];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == 3'd7);
   assign rsp_too_long    = tl_ff;

endmodule

/* sv/shamh_checker.sv */
// Port-level checker for the SHA-256 message hasher, bound to the top level.
module shamh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_data_byte,
   input logic        req_has_byte,
   input logic        req_end_of_message,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word,
   input logic        rsp_too_long
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word))
      else $error("result beat dropped or changed while stalled");

   // digest words follow one another without a gap
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=> rsp_valid)
      else $error("digest burst broken before last word");

   // word index counts up beat by beat
   a_rsp_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid ||
         rsp_word_index == 3'($past(rsp_word_index) + 3'd1))
      else $error("digest word index out of order");

   // too_long is the same on every word of one digest
   a_rsp_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=> rsp_too_long == $past(rsp_too_long))
      else $error("too_long changed within a digest");

   // an empty beat leaves the input side ready
   a_req_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_has_byte && !req_end_of_message |=> req_ready)
      else $error("empty beat stalled the input");

endmodule

bind sha256_message_hasher_unit shamh_checker u_shamh_checker (.*);

/* test/sha256_message_hasher_unit_test.sv */
// Self-checking testbench for the SHA-256 message hasher: directed vectors, then random messages.
module sha256_message_hasher_unit_test;

   // Round constants and initial hash, kept independent of the design package
   localparam logic [0:63][31:0] SHA_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam logic [0:7][31:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };
   localparam logic [63:0] LEN_LIMIT = 64'h1FFF_FFFF_FFFF_FFFF;

   // Well-known digests, word 0 in the top bits
   localparam logic [255:0] EMPTY_MSG_DIGEST =
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
      logic        too_long;
   } digest_beat_type;

   typedef struct packed {
      logic [7:0]   data;
      logic         has;
      logic         eom;
      logic         known;
      logic [255:0] digest;
   } script_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        rsp_too_long;

   // Hash state mirrored by the testbench
   logic [31:0] chain_h [8];
   logic [7:0]  block_bytes [64];
   int unsigned block_fill;
   logic [63:0] msg_len;
   logic        msg_over;

   digest_beat_type digest_beats [$];
   digest_beat_type head_beat;
   int unsigned  error_count = 0;
   int unsigned  items_sent = 0;
   int unsigned  messages_sent = 0;
   int unsigned  words_checked = 0;
   int unsigned  longest_msg = 0;
   int unsigned  burst_left = 0;

   sha256_message_hasher_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .rsp_too_long       (rsp_too_long)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [31:0] rot_right(logic [31:0] v, int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic void restart_message();
      for (int k = 0; k < 8; k++) chain_h[k] = SHA_IV[k];
      for (int k = 0; k < 64; k++) block_bytes[k] = 8'h00;
      block_fill = 0;
      msg_len = '0;
      msg_over = 1'b0;
   endfunction

   // One 64-round compression of block_bytes into chain_h
   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int r = 0; r < 16; r++)
         w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
      for (int r = 16; r < 64; r++) begin
         s0 = rot_right(w[r-15], 7) ^ rot_right(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = rot_right(w[r-2], 17) ^ rot_right(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = w[r-16] + s0 + w[r-7] + s1;
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int r = 0; r < 64; r++) begin
         t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25)) +
              ((e & f) ^ (~e & g)) + SHA_K[r] + w[r];
         t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22)) +
              ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endfunction

   // Take one accepted beat; returns 1 with the digest when the message closes
   function automatic bit absorb_beat(input logic [7:0] data, input logic has, input logic eom,
                                      output logic [255:0] digest, output logic overflow);
      logic [63:0] bit_len;
      digest = '0;
      overflow = 1'b0;
      if (has) begin
         block_bytes[block_fill] = data;
         block_fill++;
         msg_len++;
         if (msg_len > LEN_LIMIT) msg_over = 1'b1;
         if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
         end
      end
      if (!eom) return 1'b0;
      // pad: marker, zeros, bit length; spill into an extra block if the length won't fit
      bit_len = msg_len << 3;
      block_bytes[block_fill] = 8'h80;
      block_fill++;
      if (block_fill > 56) begin
         for (int k = block_fill; k < 64; k++) block_bytes[k] = 8'h00;
         compress_block();
         block_fill = 0;
      end
      for (int k = block_fill; k < 56; k++) block_bytes[k] = 8'h00;
      for (int k = 0; k < 8; k++) block_bytes[56+k] = bit_len[63-8*k -: 8];
      compress_block();
      for (int k = 0; k < 8; k++) digest[255-32*k -: 32] = chain_h[k];
      overflow = msg_over;
      restart_message();
      return 1'b1;
   endfunction

   function automatic void queue_digest(logic [255:0] digest, logic overflow);
      for (int k = 0; k < 8; k++)
         digest_beats.push_back('{digest[255-32*k -: 32], k[2:0], k == 7, overflow});
   endfunction

   function automatic script_row_type row(logic [7:0] data, logic has, logic eom,
                                          logic known = 1'b0, logic [255:0] digest = '0);
      return '{data, has, eom, known, digest};
   endfunction

   // Drive one beat in bursts with random gaps; predict on acceptance
   task automatic send_beat(input logic [7:0] data, input logic has, input logic eom,
                            input logic known = 1'b0, input logic [255:0] typed = '0);
      logic [255:0] dig;
      logic         ovf;
      int unsigned  gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_has_byte <= has;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (absorb_beat(data, has, eom, dig, ovf)) begin
         messages_sent++;
         if (known) queue_digest(typed, 1'b0);
         else queue_digest(dig, ovf);
      end
   endtask

   // Hold the sender off until every digest word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (digest_beats.size() != 0);
   endtask

   // Random message with noise beats mixed in; the closing flag rides the last byte or its own beat
   task automatic random_message();
      int unsigned len;
      logic        eom_on_byte;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: len = $urandom_range(0, 10);
         4, 5, 6:    len = $urandom_range(0, 1) ? $urandom_range(54, 57) : $urandom_range(63, 65);
         7, 8:       len = $urandom_range(11, 80);
         default:    len = $urandom_range(118, 130);
      endcase
      if (len > longest_msg) longest_msg = len;
      eom_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_beat(8'($urandom_range(0, 255)), 1'b1, eom_on_byte && (i == len - 1));
      end
      if (!eom_on_byte) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Receiver: phases of always-ready, random stalls and long stalls
   initial begin
      int unsigned stall_left;
      int unsigned phase;
      stall_left = 0;
      phase = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         phase++;
         case ((phase / 512) % 3)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 2) != 0);
            default: begin
               if (stall_left != 0) begin
                  stall_left--;
                  rsp_ready <= 1'b0;
               end else if ($urandom_range(0, 3) == 0) begin
                  stall_left = $urandom_range(1, 20);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Digest word checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_beats.size() == 0) begin
            $error("digest beat with none pending: word %h index %0d", rsp_digest_word,
                   rsp_word_index);
            error_count++;
         end else begin
            head_beat = digest_beats.pop_front();
            words_checked++;
            if (rsp_digest_word !== head_beat.word) begin
               $error("digest_word: expected %h, got %h", head_beat.word, rsp_digest_word);
               error_count++;
            end
            if (rsp_word_index !== head_beat.index) begin
               $error("word_index: expected %0d, got %0d", head_beat.index, rsp_word_index);
               error_count++;
            end
            if (rsp_last_word !== head_beat.last) begin
               $error("last_word: expected %b, got %b", head_beat.last, rsp_last_word);
               error_count++;
            end
            if (rsp_too_long !== head_beat.too_long) begin
               $error("too_long: expected %b, got %b", head_beat.too_long, rsp_too_long);
               error_count++;
            end
         end
      end
   end

   initial begin
      script_row_type script [$];
      int unsigned random_start;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_has_byte <= 1'b0;
      req_end_of_message <= 1'b0;
      restart_message();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty beat, empty message, "abc" both ways, byte extremes
      script.push_back(row(8'h5a, 1'b0, 1'b0));
      script.push_back(row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_MSG_DIGEST));
      script.push_back(row(8'h61, 1'b1, 1'b0));
      script.push_back(row(8'h62, 1'b1, 1'b0));
      script.push_back(row(8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST));
      script.push_back(row(8'h00, 1'b1, 1'b0));
      script.push_back(row(8'hff, 1'b1, 1'b0));
      script.push_back(row(8'ha5, 1'b0, 1'b0));
      script.push_back(row(8'hff, 1'b0, 1'b1));
      script.push_back(row(8'hff, 1'b1, 1'b1));
      script.push_back(row(8'h00, 1'b1, 1'b1));
      script.push_back(row(8'h61, 1'b1, 1'b0));
      script.push_back(row(8'h62, 1'b1, 1'b0));
      script.push_back(row(8'h63, 1'b1, 1'b0));
      script.push_back(row(8'h00, 1'b0, 1'b1, 1'b1, ABC_DIGEST));
      script.push_back(row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_MSG_DIGEST));
      foreach (script[i])
         send_beat(script[i].data, script[i].has, script[i].eom, script[i].known,
                   script[i].digest);
      drain_results();

      // Random messages, mostly well formed, with block-boundary lengths favored
      random_start = items_sent;
      while (items_sent - random_start < 200) begin
         random_message();
         if ($urandom_range(0, 4) == 0) drain_results();
      end
      req_valid <= 1'b0;

      while (digest_beats.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d beats in %0d messages (longest %0d bytes), checked %0d digest words.",
               items_sent, messages_sent, longest_msg, words_checked);
      $display("Length overflow flag was only checked at zero; it needs over 2^61 bytes.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
